/* rtl/prt_pkg.sv */
// Shared types and codes for the parameter ramp table.
// Holds the action codes and the controller state type; no dependencies.
package prt_pkg;

    // Action codes carried on the action input.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_RAMP = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_READ,
        ST_CALC,
        ST_FINISH
    } state_t;

endpackage

/* rtl/prt_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Width and depth are parameters; no package dependency.
module prt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read share one clock edge.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/parameter_ramp_table_top.sv */
// Top level of the parameter ramp table: controller, arithmetic and two table RAMs.
// Depends on prt_pkg and prt_ram.

// The block holds ENTRIES linear ramps in Q16.16. An item is taken when start
// is high and busy is low; busy then stays high until the result is out. A
// load writes the table in the LOAD state and registers its result; a ramp
// goes through READ (address presented, registered RAM read), CALC
// (step-times-ticks multiply registered) and FINISH (add, saturate, clamp
// and write-back). The next item may be started in the cycle in which the
// result appears. Each result is shown for exactly one cycle with done high;
// the receiver cannot stall it, so it must take the item in that cycle.
// Entry indexes wrap modulo ENTRIES, and an entry must be loaded before it is
// ramped.
module parameter_ramp_table_top #(
    parameter int ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               action,
    input  logic [5:0]         entry_index,
    input  logic [7:0]         elapsed_ticks,
    input  logic signed [31:0] load_current,
    input  logic signed [31:0] load_target,
    input  logic signed [31:0] load_step,
    output logic               done,
    output logic               reached,
    output logic signed [31:0] new_value
);

    import prt_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    // Wrap a six-bit index into the table through a small constant table.
    function automatic logic [AW-1:0] wrap_index(input logic [5:0] idx);
        logic [AW-1:0] r;
        r = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (idx == 6'(i))
            begin
                r = AW'(i % ENTRIES);
            end
        end
        return r;
    endfunction

    state_t state_reg, state_next;

    // Captured item.
    logic               action_reg;
    logic [AW-1:0]      idx_reg;
    logic [7:0]         ticks_reg;
    logic signed [31:0] ld_cur_reg;
    logic signed [31:0] ld_tgt_reg;
    logic signed [31:0] ld_step_reg;

    // Multiply stage registers.
    logic signed [39:0] prod_reg;
    logic signed [31:0] cur_reg;
    logic signed [31:0] tgt_reg;
    logic               step_pos_reg;

    // Result registers.
    logic               done_reg;
    logic               reached_reg;
    logic signed [31:0] value_reg;

    // RAM ports.
    logic               cur_we;
    logic [31:0]        cur_wdata;
    logic [31:0]        cur_rdata;
    logic               ts_we;
    logic [63:0]        ts_wdata;
    logic [63:0]        ts_rdata;

    // Datapath signals.
    logic               accept;
    logic signed [31:0] rd_tgt;
    logic signed [31:0] rd_step;
    logic signed [8:0]  ticks_s;
    logic signed [40:0] prod_full;
    logic signed [34:0] delta;
    logic signed [35:0] sum_wide;
    logic signed [31:0] sum_sat;
    logic signed [31:0] clamped;
    logic               at_target;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Current values live in one RAM, target and step side by side in another.
    prt_ram #(
        .WIDTH (32),
        .DEPTH (ENTRIES)
    ) u_cur_ram (
        .clk   (clk),
        .we    (cur_we),
        .waddr (idx_reg),
        .wdata (cur_wdata),
        .raddr (idx_reg),
        .rdata (cur_rdata)
    );

    prt_ram #(
        .WIDTH (64),
        .DEPTH (ENTRIES)
    ) u_ts_ram (
        .clk   (clk),
        .we    (ts_we),
        .waddr (idx_reg),
        .wdata (ts_wdata),
        .raddr (idx_reg),
        .rdata (ts_rdata)
    );

    assign rd_tgt  = signed'(ts_rdata[63:32]);
    assign rd_step = signed'(ts_rdata[31:0]);

    // Step times ticks, exact, ticks taken as unsigned.
    assign ticks_s   = signed'({1'b0, ticks_reg});
    assign prod_full = rd_step * ticks_s;

    // Arithmetic shift by five is the floor of a division by 32.
    assign delta    = prod_reg[39:5];
    assign sum_wide = 36'(cur_reg) + 36'(delta);

    // Saturate the sum to the signed 32-bit range.
    always_comb
    begin
        if (sum_wide > 36'(VAL_MAX))
        begin
            sum_sat = VAL_MAX;
        end
        else if (sum_wide < 36'(VAL_MIN))
        begin
            sum_sat = VAL_MIN;
        end
        else
        begin
            sum_sat = sum_wide[31:0];
        end
    end

    // Clamp at the target from the side the step moves toward.
    always_comb
    begin
        if (step_pos_reg)
        begin
            clamped = (sum_sat >= tgt_reg) ? tgt_reg : sum_sat;
        end
        else
        begin
            clamped = (sum_sat <= tgt_reg) ? tgt_reg : sum_sat;
        end
    end

    assign at_target = (cur_reg == tgt_reg);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (action == ACT_LOAD) ? ST_LOAD : ST_READ;
                end
            end
            ST_LOAD:   state_next = ST_IDLE;
            ST_READ:   state_next = ST_CALC;
            ST_CALC:   state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Table write controls.
    always_comb
    begin
        cur_we    = 1'b0;
        ts_we     = 1'b0;
        cur_wdata = ld_cur_reg;
        ts_wdata  = {ld_tgt_reg, ld_step_reg};
        unique case (state_reg)
            ST_LOAD:
            begin
                cur_we = 1'b1;
                ts_we  = 1'b1;
            end
            ST_FINISH:
            begin
                cur_we    = !at_target;
                cur_wdata = clamped;
            end
            default:
            begin
                cur_we = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_LOAD) || (state_reg == ST_FINISH);
        end
    end

    // Item capture, multiply stage and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg  <= action;
            idx_reg     <= wrap_index(entry_index);
            ticks_reg   <= elapsed_ticks;
            ld_cur_reg  <= load_current;
            ld_tgt_reg  <= load_target;
            ld_step_reg <= load_step;
        end
        if (state_reg == ST_CALC)
        begin
            prod_reg     <= prod_full[39:0];
            cur_reg      <= signed'(cur_rdata);
            tgt_reg      <= rd_tgt;
            step_pos_reg <= (rd_step > 32'sd0);
        end
        if (state_reg == ST_LOAD)
        begin
            reached_reg <= 1'b0;
            value_reg   <= ld_cur_reg;
        end
        else if (state_reg == ST_FINISH && action_reg == ACT_RAMP)
        begin
            reached_reg <= at_target;
            value_reg   <= at_target ? cur_reg : clamped;
        end
    end

    assign done      = done_reg;
    assign reached   = reached_reg;
    assign new_value = value_reg;

endmodule

/* rtl/prt_checker.sv */
// Port-level assertions for the parameter ramp table and the bind that attaches them.
// Depends on prt_pkg and parameter_ramp_table_top.
module prt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               action,
    input logic signed [31:0] load_current,
    input logic               done,
    input logic               reached,
    input logic signed [31:0] new_value
);

    import prt_pkg::*;

    // A taken item holds the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an item was taken");

    // A result only follows a busy cycle.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a preceding busy cycle");

    // Busy drops exactly when a result is shown.
    a_busy_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // A taken load echoes its current value as the result, with reached low.
    a_load_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_LOAD) |=> ##1
        (done && !reached && new_value == $past(load_current, 2)))
        else $error("load result does not echo the loaded current value");

endmodule

bind parameter_ramp_table_top prt_checker u_prt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .load_current (load_current),
    .done         (done),
    .reached      (reached),
    .new_value    (new_value)
);
